FILE: design/tbpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types and constants for the two-button press classifier.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    localparam int unsigned THR_W = 32;
    localparam int unsigned NOW_W = 32;

    localparam logic [THR_W-1:0] LONG_PRESS_RESET = 32'd1000;

    typedef struct packed {
        logic a_short_press;
        logic a_long_press;
        logic b_short_press;
        logic b_long_press;
        logic chord_long_press;
    } tbpc_events_t;

endpackage : tbpc_pkg
`default_nettype wire

FILE: design/tbpc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbpc_core
// Press tracking state for both buttons and the chord; classifies one scan
// sample per step and updates the tracking state.
// ----------------------------------------------------------------------------
module tbpc_core #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic                         a_down,
    input  wire logic                         b_down,
    input  wire logic [tbpc_pkg::NOW_W-1:0]   now,
    input  wire logic [tbpc_pkg::THR_W-1:0]   thr,
    output tbpc_pkg::tbpc_events_t            events
);
    import tbpc_pkg::*;

    localparam int unsigned CMP_W = (TICK_BITS > THR_W) ? TICK_BITS : THR_W;

    logic                 a_held_reg, a_held_next;
    logic [TICK_BITS-1:0] a_start_reg, a_start_next;
    logic                 a_long_done_reg, a_long_done_next;
    logic                 b_held_reg, b_held_next;
    logic [TICK_BITS-1:0] b_start_reg, b_start_next;
    logic                 b_long_done_reg, b_long_done_next;
    logic                 chord_held_reg, chord_held_next;
    logic [TICK_BITS-1:0] chord_start_reg, chord_start_next;
    logic                 chord_done_reg, chord_done_next;

    logic [TICK_BITS-1:0] now_t;
    logic [TICK_BITS-1:0] a_dur, b_dur, chord_dur;
    logic                 a_reached, b_reached, chord_reached;

    assign now_t     = TICK_BITS'(now);
    assign a_dur     = now_t - a_start_reg;
    assign b_dur     = now_t - b_start_reg;
    assign chord_dur = now_t - chord_start_reg;

    assign a_reached     = CMP_W'(a_dur) >= CMP_W'(thr);
    assign b_reached     = CMP_W'(b_dur) >= CMP_W'(thr);
    assign chord_reached = CMP_W'(chord_dur) >= CMP_W'(thr);

    always_comb
    begin
        a_held_next      = a_held_reg;
        a_start_next     = a_start_reg;
        a_long_done_next = a_long_done_reg;
        b_held_next      = b_held_reg;
        b_start_next     = b_start_reg;
        b_long_done_next = b_long_done_reg;
        chord_held_next  = chord_held_reg;
        chord_start_next = chord_start_reg;
        chord_done_next  = chord_done_reg;
        events           = '0;

        if (step)
        begin
            if (a_down && b_down)
            begin
                if (!chord_held_reg)
                begin
                    chord_held_next  = 1'b1;
                    chord_start_next = now_t;
                    chord_done_next  = 1'b0;
                    a_held_next      = 1'b0;
                    b_held_next      = 1'b0;
                    a_long_done_next = 1'b0;
                end
                else if (!chord_done_reg && chord_reached)
                begin
                    chord_done_next         = 1'b1;
                    events.chord_long_press = 1'b1;
                end
            end
            else
            begin
                chord_held_next = 1'b0;

                if (a_down && !a_held_reg)
                begin
                    a_held_next      = 1'b1;
                    a_start_next     = now_t;
                    a_long_done_next = 1'b0;
                end
                else if (a_down && a_held_reg)
                begin
                    if (a_reached && !a_long_done_reg)
                    begin
                        a_long_done_next    = 1'b1;
                        events.a_long_press = 1'b1;
                    end
                end
                else if (!a_down && a_held_reg)
                begin
                    a_held_next = 1'b0;
                    if (!a_reached)
                    begin
                        a_long_done_next     = 1'b0;
                        events.a_short_press = 1'b1;
                    end
                end

                if (b_down && !b_held_reg)
                begin
                    b_held_next      = 1'b1;
                    b_start_next     = now_t;
                    b_long_done_next = 1'b0;
                end
                else if (b_down && b_held_reg)
                begin
                    if (b_reached && !b_long_done_reg)
                    begin
                        b_long_done_next    = 1'b1;
                        events.b_long_press = 1'b1;
                    end
                end
                else if (!b_down && b_held_reg)
                begin
                    b_held_next = 1'b0;
                    if (!b_long_done_reg)
                    begin
                        events.b_short_press = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_held_reg      <= 1'b0;
            a_start_reg     <= '0;
            a_long_done_reg <= 1'b0;
            b_held_reg      <= 1'b0;
            b_start_reg     <= '0;
            b_long_done_reg <= 1'b0;
            chord_held_reg  <= 1'b0;
            chord_start_reg <= '0;
            chord_done_reg  <= 1'b0;
        end
        else
        begin
            a_held_reg      <= a_held_next;
            a_start_reg     <= a_start_next;
            a_long_done_reg <= a_long_done_next;
            b_held_reg      <= b_held_next;
            b_start_reg     <= b_start_next;
            b_long_done_reg <= b_long_done_next;
            chord_held_reg  <= chord_held_next;
            chord_start_reg <= chord_start_next;
            chord_done_reg  <= chord_done_next;
        end
    end

    // chord onset drops single-button tracking
    assert property (@(posedge clk) disable iff (!rst_n)
        step && a_down && b_down && !chord_held_reg
        |=> chord_held_reg && !chord_done_reg && !a_held_reg && !b_held_reg)
        else $error("chord onset did not clear single tracking");

    // a chord event excludes every single-button event in the same sample
    assert property (@(posedge clk) disable iff (!rst_n)
        events.chord_long_press |-> !(events.a_short_press || events.a_long_press
                                      || events.b_short_press || events.b_long_press))
        else $error("chord event mixed with single events");

    // a long press fires once per press
    assert property (@(posedge clk) disable iff (!rst_n)
        events.a_long_press |=> a_long_done_reg && a_held_reg)
        else $error("a long press not recorded");

    assert property (@(posedge clk) disable iff (!rst_n)
        events.chord_long_press |=> chord_done_reg)
        else $error("chord event not recorded");

endmodule : tbpc_core
`default_nettype wire

FILE: design/two_button_press_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_button_press_classifier
// Classifies short, long and chord presses of two buttons from scan samples.
// ----------------------------------------------------------------------------
// an accepted input beat passes the input register, then the output register
// throughput: one sample per cycle unless out_ready stalls the output; input register feeds one compare stage
// the output register holds a stalled result while the next sample waits
// reset: all tracking cleared, threshold back to 1000 ticks, no beats pending
// ----------------------------------------------------------------------------
module two_button_press_classifier #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tbpc_pkg::THR_W-1:0]   cfg_data,

    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         button_a_down,
    input  wire logic                         button_b_down,
    input  wire logic [tbpc_pkg::NOW_W-1:0]   now_tick,

    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              a_short_press,
    output logic                              a_long_press,
    output logic                              b_short_press,
    output logic                              b_long_press,
    output logic                              chord_long_press
);
    import tbpc_pkg::*;

    logic [THR_W-1:0] long_press_ticks_reg;

    logic             s1_valid_reg;
    logic             s1_a_reg;
    logic             s1_b_reg;
    logic [NOW_W-1:0] s1_now_reg;

    logic             out_valid_reg;
    tbpc_events_t     out_events_reg;

    logic             advance;
    logic             step;
    tbpc_events_t     events;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign step      = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            long_press_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_a_reg   <= button_a_down;
            s1_b_reg   <= button_b_down;
            s1_now_reg <= now_tick;
        end
        if (step)
        begin
            out_events_reg <= events;
        end
    end

    tbpc_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .a_down (s1_a_reg),
        .b_down (s1_b_reg),
        .now    (s1_now_reg),
        .thr    (long_press_ticks_reg),
        .events (events)
    );

    assign out_valid        = out_valid_reg;
    assign a_short_press    = out_events_reg.a_short_press;
    assign a_long_press     = out_events_reg.a_long_press;
    assign b_short_press    = out_events_reg.b_short_press;
    assign b_long_press     = out_events_reg.b_long_press;
    assign chord_long_press = out_events_reg.chord_long_press;

    // a stalled result must not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_events_reg))
        else $error("stalled result lost");

    // a sample in the input register reaches the output once the output frees
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> out_valid_reg)
        else $error("sample dropped between stages");

    // the input register only refills when it empties or moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_now_reg))
        else $error("input register overwritten while stalled");

endmodule : two_button_press_classifier
`default_nettype wire

FILE: verif/two_button_press_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_button_press_classifier_tb
// Self-checking bench for the two-button press classifier.
// Scan samples go in over a valid/ready channel. Each accepted sample is
// classified by a behavioral model kept in the bench, and every result beat
// is compared field by field with the oldest prediction. Directed sequences
// cover short, long and chord presses, releases at the threshold, tick wrap
// and the threshold extremes. Random phases then mix press sequences aimed
// at the threshold with noise, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module two_button_press_classifier_tb;
    import tbpc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned DRAIN_CYCLES   = 8;

    logic             clk              = 1'b0;
    logic             rst_n            = 1'b0;
    logic             cfg_valid        = 1'b0;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data         = '0;
    logic             in_valid         = 1'b0;
    logic             in_ready;
    logic             button_a_down    = 1'b0;
    logic             button_b_down    = 1'b0;
    logic [NOW_W-1:0] now_tick         = '0;
    logic             out_valid;
    logic             out_ready        = 1'b0;
    logic             a_short_press;
    logic             a_long_press;
    logic             b_short_press;
    logic             b_long_press;
    logic             chord_long_press;

    int unsigned      send_idle_pct    = 0;
    int unsigned      recv_stall_pct   = 0;
    int unsigned      fail_count       = 0;
    int unsigned      quiet_cycles     = 0;

    tbpc_events_t     pending_events[$];

    // classifier state kept by the bench
    logic [THR_W-1:0] hold_limit       = LONG_PRESS_RESET;
    logic             a_pressed        = 1'b0;
    logic [NOW_W-1:0] a_since          = '0;
    logic             a_long_fired     = 1'b0;
    logic             b_pressed        = 1'b0;
    logic [NOW_W-1:0] b_since          = '0;
    logic             b_long_fired     = 1'b0;
    logic             chord_on         = 1'b0;
    logic [NOW_W-1:0] chord_since      = '0;
    logic             chord_fired      = 1'b0;

    two_button_press_classifier u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .button_a_down    (button_a_down),
        .button_b_down    (button_b_down),
        .now_tick         (now_tick),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .a_short_press    (a_short_press),
        .a_long_press     (a_long_press),
        .b_short_press    (b_short_press),
        .b_long_press     (b_long_press),
        .chord_long_press (chord_long_press)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic held_long(input logic [NOW_W-1:0] now,
                                       input logic [NOW_W-1:0] since);
        logic [NOW_W-1:0] span;
        span = now - since;
        return span >= hold_limit;
    endfunction

    function automatic tbpc_events_t classify_scan(input logic a, input logic b,
                                                   input logic [NOW_W-1:0] now);
        tbpc_events_t ev;
        ev = '0;
        if (a && b)
        begin
            if (!chord_on)
            begin
                chord_on     = 1'b1;
                chord_since  = now;
                chord_fired  = 1'b0;
                a_pressed    = 1'b0;
                b_pressed    = 1'b0;
                a_long_fired = 1'b0;
            end
            else if (!chord_fired && held_long(now, chord_since))
            begin
                chord_fired         = 1'b1;
                ev.chord_long_press = 1'b1;
            end
        end
        else
        begin
            chord_on = 1'b0;
            if (a && !a_pressed)
            begin
                a_pressed    = 1'b1;
                a_since      = now;
                a_long_fired = 1'b0;
            end
            else if (a && a_pressed)
            begin
                if (held_long(now, a_since) && !a_long_fired)
                begin
                    a_long_fired    = 1'b1;
                    ev.a_long_press = 1'b1;
                end
            end
            else if (!a && a_pressed)
            begin
                a_pressed = 1'b0;
                if (!held_long(now, a_since))
                begin
                    a_long_fired     = 1'b0;
                    ev.a_short_press = 1'b1;
                end
            end

            if (b && !b_pressed)
            begin
                b_pressed    = 1'b1;
                b_since      = now;
                b_long_fired = 1'b0;
            end
            else if (b && b_pressed)
            begin
                if (held_long(now, b_since) && !b_long_fired)
                begin
                    b_long_fired    = 1'b1;
                    ev.b_long_press = 1'b1;
                end
            end
            else if (!b && b_pressed)
            begin
                b_pressed = 1'b0;
                if (!b_long_fired)
                    ev.b_short_press = 1'b1;
            end
        end
        return ev;
    endfunction

    task automatic report_failure(input string what);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic send_scan(input logic a, input logic b, input logic [NOW_W-1:0] t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        button_a_down <= a;
        button_b_down <= b;
        now_tick      <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_events.push_back(classify_scan(a, b, t));
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        hold_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_threshold_presses();
        send_scan(1'b0, 1'b0, 32'd0);
        // A short, then A long, then A released past the threshold
        send_scan(1'b1, 1'b0, 32'd100);
        send_scan(1'b0, 1'b0, 32'd1099);
        send_scan(1'b1, 1'b0, 32'd2000);
        send_scan(1'b1, 1'b0, 32'd3000);
        send_scan(1'b0, 1'b0, 32'd4000);
        // B long across the tick wrap, then B short after a long hold
        send_scan(1'b0, 1'b1, 32'hFFFF_FF00);
        send_scan(1'b0, 1'b1, 32'h0000_02E8);
        send_scan(1'b0, 1'b0, 32'h0000_0300);
        send_scan(1'b0, 1'b1, 32'd5000);
        send_scan(1'b0, 1'b0, 32'd9000);
        // chord onset clears A, fires at the threshold, A restarts on leaving
        send_scan(1'b1, 1'b0, 32'd10000);
        send_scan(1'b1, 1'b1, 32'd10500);
        send_scan(1'b1, 1'b1, 32'd11499);
        send_scan(1'b1, 1'b1, 32'd11500);
        send_scan(1'b1, 1'b0, 32'd20001);
        send_scan(1'b0, 1'b0, 32'd20002);
        send_scan(1'b1, 1'b1, 32'hFFFF_FFFF);
        pause_until_drained();
    endtask

    task automatic test_threshold_extremes();
        write_threshold('0);
        send_scan(1'b1, 1'b0, 32'd5);
        send_scan(1'b1, 1'b0, 32'd5);
        pause_until_drained();
        write_threshold('1);
        send_scan(1'b1, 1'b0, 32'h0000_0010);
        send_scan(1'b1, 1'b0, 32'h0000_000F);
        pause_until_drained();
    endtask

    task automatic test_random_scans(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [THR_W-1:0] limit);
        logic             a;
        logic             b;
        logic [NOW_W-1:0] tick;
        logic [THR_W-1:0] span;
        a    = 1'b0;
        b    = 1'b0;
        tick = $urandom();
        span = limit >> 1;
        pause_until_drained();
        write_threshold(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i == count / 2)
                pause_until_drained();
            if ($urandom_range(9) == 0)
            begin
                a    = 1'($urandom_range(1));
                b    = 1'($urandom_range(1));
                tick = $urandom();
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    a = !a;
                if ($urandom_range(3) == 0)
                    b = !b;
                // aim at the threshold boundary of a live press now and then
                case ($urandom_range(9))
                    0:       tick = tick;
                    1, 2:    tick = tick + $urandom_range(3);
                    3, 4, 5: tick = tick + $urandom_range(span);
                    6:       tick = a_since + limit + $urandom_range(2) - 1;
                    7:       tick = b_since + limit + $urandom_range(2) - 1;
                    8:       tick = chord_since + limit + $urandom_range(2) - 1;
                    default: tick = tick - $urandom_range(3);
                endcase
            end
            send_scan(a, b, tick);
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        tbpc_events_t got;
        tbpc_events_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {a_short_press, a_long_press, b_short_press, b_long_press,
                   chord_long_press};
            if (pending_events.size() == 0)
                report_failure($sformatf("result beat %b with nothing expected", got));
            else
            begin
                want = pending_events.pop_front();
                if (got.a_short_press !== want.a_short_press)
                    report_failure($sformatf("a_short_press expected %b got %b",
                                             want.a_short_press, got.a_short_press));
                if (got.a_long_press !== want.a_long_press)
                    report_failure($sformatf("a_long_press expected %b got %b",
                                             want.a_long_press, got.a_long_press));
                if (got.b_short_press !== want.b_short_press)
                    report_failure($sformatf("b_short_press expected %b got %b",
                                             want.b_short_press, got.b_short_press));
                if (got.b_long_press !== want.b_long_press)
                    report_failure($sformatf("b_long_press expected %b got %b",
                                             want.b_long_press, got.b_long_press));
                if (got.chord_long_press !== want.chord_long_press)
                    report_failure($sformatf("chord_long_press expected %b got %b",
                                             want.chord_long_press, got.chord_long_press));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
                         $realtime, WATCHDOG_LIMIT, pending_events.size());
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_default_threshold_presses();
        test_threshold_extremes();
        test_random_scans(390, 0, 0, 32'd20);
        test_random_scans(390, 67, 0, 32'd1);
        test_random_scans(390, 0, 67, 32'd300);
        test_random_scans(390, 21, 21, 32'hFFFF_FFFF);
        test_random_scans(390, 0, 0, LONG_PRESS_RESET);
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
